// ===== sv/fir_pkg.sv =====
// Shared widths, constants and types of the direct-form FIR filter.
// No dependencies; compiled first.
`default_nettype none

package fir_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 18;
	localparam int INDEX_W  = 6;
	localparam int TAPCNT_W = 7;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int FRAC_SHIFT = 16;

	typedef logic [1:0] action_t;

	localparam action_t ACT_FILTER = 2'd0;
	localparam action_t ACT_LOAD   = 2'd1;
	localparam action_t ACT_CLEAR  = 2'd2;

	localparam logic signed [COEF_W-1:0]   COEF_UNITY = 18'sd65536;
	localparam logic signed [SAMPLE_W-1:0] OUT_MAX    = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN    = 16'sh8000;

endpackage

`default_nettype wire

// ===== sv/fir_ifs.sv =====
// Handshake channels of the FIR filter: request, result and configuration.
// Depends on fir_pkg.
`default_nettype none

interface fir_req_if import fir_pkg::*; ();
	logic                       valid;
	logic                       ready;
	action_t                    action;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [INDEX_W-1:0]         coef_index;
	logic signed [COEF_W-1:0]   coef_value;

	modport source (output valid, action, sample_in, coef_index, coef_value, input ready);
	modport sink   (input valid, action, sample_in, coef_index, coef_value, output ready);
endinterface

interface fir_rsp_if import fir_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       saturated;

	modport source (output valid, sample_out, saturated, input ready);
	modport sink   (input valid, sample_out, saturated, output ready);
endinterface

interface fir_cfg_if import fir_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [TAPCNT_W-1:0] tap_count;

	modport source (output valid, tap_count, input ready);
	modport sink   (input valid, tap_count, output ready);
endinterface

`default_nettype wire

// ===== sv/fir_filter_direct_form_core.sv =====
// Direct-form FIR filter core: coefficient and history memories, MAC sequencer.
// Depends on fir_pkg and the channel interfaces in fir_ifs.sv.
//
//   channel  dir  word carries
//   req      in   action, sample_in, coef_index, coef_value
//   rsp      out  sample_out, saturated (one word per filtered sample)
//   cfg      in   tap_count, always ready
//
// A sample word occupies the core while its taps are accumulated, one
// multiply-accumulate per cycle through a single multiplier fed by the two
// memory read ports, then while the read and multiply registers drain and the rounded result is registered.
// A clear word sweeps the history memory; a load leaves the core idle.
// After reset an initialisation pass over all TAPS entries writes both memories
// before the first word is taken. A stalled result waits in the output
// register; the next word is taken meanwhile and holds in its final stage.
`default_nettype none

module fir_filter_direct_form_core import fir_pkg::*; #(
	parameter int TAPS = 64
) (
	input  wire       clk,
	input  wire       arst_n,
	fir_req_if.sink   req,
	fir_rsp_if.source rsp,
	fir_cfg_if.sink   cfg
);

	localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int NW    = $clog2(TAPS + 1);
	localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;
	localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
	localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] Q_MAX      = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] Q_MIN      = ACC_W'(-32768);

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_CLEAR, ST_RUN, ST_DRAIN, ST_OUT
	} state_t;

	state_t              state_q;
	logic [TAPCNT_W-1:0] tap_count_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       raddr_q;
	logic [AW-1:0]       sweep_q;
	logic [NW-1:0]       cnt_q;
	logic [NW-1:0]       n_q;
	logic                out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                out_sat_q;

	logic signed [COEF_W-1:0]   coef_mem [TAPS];
	logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
	logic signed [COEF_W-1:0]   coef_rd_s1;
	logic signed [SAMPLE_W-1:0] hist_rd_s1;
	logic                       v_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       v_s2;
	logic signed [ACC_W-1:0]    acc_q;

	logic                       req_acc;
	logic                       sweeping;
	logic [AW-1:0]              head_next;
	logic [NW-1:0]              n_sel;
	logic                       last_tap;
	logic                       coef_we;
	logic [AW-1:0]              coef_waddr;
	logic signed [COEF_W-1:0]   coef_wdata;
	logic                       hist_we;
	logic [AW-1:0]              hist_waddr;
	logic signed [SAMPLE_W-1:0] hist_wdata;
	logic signed [ACC_W-1:0]    acc_round;
	logic signed [ACC_W-1:0]    q_val;
	logic                       sat_hi;
	logic                       sat_lo;
	logic                       out_load;

	assign req.ready   = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign rsp.valid      = out_valid_q;
	assign rsp.sample_out = out_sample_q;
	assign rsp.saturated  = out_sat_q;

	assign req_acc  = req.valid && req.ready;
	assign sweeping = (state_q == ST_INIT) || (state_q == ST_CLEAR);
	assign head_next = (head_q == LAST) ? '0 : head_q + AW'(1);
	assign last_tap  = (cnt_q + NW'(1)) == n_q;

	always_comb begin
		if (tap_count_q == '0) begin
			n_sel = NW'(1);
		end else if (32'(tap_count_q) > 32'(TAPS)) begin
			n_sel = NW'(TAPS);
		end else begin
			n_sel = NW'(tap_count_q);
		end
	end

	// The history is a circular buffer: the newest sample sits at head_q and
	// tap i reads head_q - i, so tap 0 sees the sample just written.
	always_comb begin
		coef_we    = (state_q == ST_INIT) ||
		             (req_acc && req.action == ACT_LOAD && 32'(req.coef_index) < 32'(TAPS));
		coef_waddr = (state_q == ST_INIT) ? sweep_q : AW'(req.coef_index);
		if (state_q == ST_INIT) begin
			coef_wdata = (sweep_q == '0) ? COEF_UNITY : '0;
		end else begin
			coef_wdata = req.coef_value;
		end
		hist_we    = sweeping || (req_acc && req.action == ACT_FILTER);
		hist_waddr = sweeping ? sweep_q : head_next;
		hist_wdata = sweeping ? '0 : req.sample_in;
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= coef_wdata;
		end
		coef_rd_s1 <= coef_mem[cnt_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_rd_s1 <= hist_mem[raddr_q];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(hist_rd_s1) * PROD_W'(coef_rd_s1);
		if (req_acc) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAPCNT_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			tap_count_q <= cfg.tap_count;
		end
	end

	// Round to nearest with ties upward, then clip to the Q1.15 range.
	assign acc_round = acc_q + ROUND_BIAS;
	assign q_val     = acc_round >>> FRAC_SHIFT;
	assign sat_hi    = q_val > Q_MAX;
	assign sat_lo    = q_val < Q_MIN;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			head_q       <= '0;
			raddr_q      <= '0;
			sweep_q      <= '0;
			cnt_q        <= '0;
			n_q          <= NW'(1);
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
			out_sat_q    <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					sweep_q <= (sweep_q == LAST) ? '0 : sweep_q + AW'(1);
					if (sweep_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						case (req.action)
							ACT_FILTER: begin
								head_q  <= head_next;
								raddr_q <= head_next;
								cnt_q   <= '0;
								n_q     <= n_sel;
								state_q <= ST_RUN;
							end
							ACT_CLEAR: begin
								sweep_q <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RUN: begin
					raddr_q <= (raddr_q == '0) ? LAST : raddr_q - AW'(1);
					cnt_q   <= cnt_q + NW'(1);
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= sat_hi ? OUT_MAX : (sat_lo ? OUT_MIN : q_val[SAMPLE_W-1:0]);
						out_sat_q    <= sat_hi || sat_lo;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A new word must find the multiply-accumulate pipeline empty.
	a_pipe_empty_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> (!v_s1 && !v_s2))
		else $error("word accepted while the MAC pipeline still holds products");

	// The tap counter never runs past the taps in use.
	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (cnt_q < n_q))
		else $error("tap counter beyond taps in use");

	// No history write may land while taps are being read.
	a_no_hist_write_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN || state_q == ST_DRAIN) |-> !hist_we)
		else $error("history written during accumulation");

	// A pending result is never overwritten.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> (out_valid_q && $stable(out_sample_q)))
		else $error("pending result overwritten");

	// A clipped result sits at one end of the output range.
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.saturated) |-> (rsp.sample_out == OUT_MAX || rsp.sample_out == OUT_MIN))
		else $error("saturation flag set on an unclipped value");

endmodule

`default_nettype wire

// ===== sim/fir_filter_direct_form_checker.sv =====
// Scoreboard for the direct-form FIR filter: it watches the request, result and
// configuration channels, predicts every filtered word and compares it.
// Depends on fir_pkg and the channel interfaces in fir_ifs.sv.
`default_nettype none

module fir_filter_direct_form_checker import fir_pkg::*; #(
	parameter int TAPS = 64
) (
	input  logic clk,
	input  logic arst_n,
	fir_req_if   req,
	fir_rsp_if   rsp,
	fir_cfg_if   cfg,
	output int   fail_count,
	output int   results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       saturated;
	} filtered_t;

	logic [TAPCNT_W-1:0]        taps_reg;
	logic signed [COEF_W-1:0]   coef_tab [TAPS];
	logic signed [SAMPLE_W-1:0] history  [TAPS];
	filtered_t                  owed_samples [$];

	// Exact sum of products, rounded half up to Q1.15 and clipped; the history
	// then moves along by one whatever the number of taps in use.
	function automatic filtered_t filter_sample(input logic signed [SAMPLE_W-1:0] x);
		longint    acc;
		longint    q;
		int        n;
		int        i;
		filtered_t r;
		n = int'(taps_reg);
		if (n < 1)
			n = 1;
		if (n > TAPS)
			n = TAPS;
		acc = longint'(x) * longint'(coef_tab[0]);
		for (i = 1; i < n; i++)
			acc += longint'(history[i-1]) * longint'(coef_tab[i]);
		q = (acc + 64'sd32768) >>> FRAC_SHIFT;
		r.saturated = 1'b0;
		if (q > 32767) begin
			q = 32767;
			r.saturated = 1'b1;
		end
		if (q < -32768) begin
			q = -32768;
			r.saturated = 1'b1;
		end
		r.sample_out = SAMPLE_W'(q);
		for (i = TAPS - 1; i > 0; i--)
			history[i] = history[i-1];
		history[0] = x;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filtered_t want;
		if (!arst_n) begin
			taps_reg = TAPCNT_W'(1);
			foreach (coef_tab[k]) begin
				coef_tab[k] = '0;
				history[k]  = '0;
			end
			coef_tab[0] = COEF_UNITY;
			owed_samples.delete();
			fail_count = 0;
			results_owed <= 0;
		end else begin
			// Results are checked before requests are taken in, so a word arriving
			// at the same edge as a new request can never be matched against it.
			if (rsp.valid && rsp.ready) begin
				if (owed_samples.size() == 0) begin
					$error("result word with no sample pending: sample_out %0d saturated %0b",
						rsp.sample_out, rsp.saturated);
					fail_count++;
				end else begin
					want = owed_samples.pop_front();
					if (rsp.sample_out !== want.sample_out) begin
						$error("sample_out: expected %0d, got %0d", want.sample_out,
							rsp.sample_out);
						fail_count++;
					end
					if (rsp.saturated !== want.saturated) begin
						$error("saturated: expected %0b, got %0b", want.saturated,
							rsp.saturated);
						fail_count++;
					end
				end
			end
			if (cfg.valid && cfg.ready)
				taps_reg = cfg.tap_count;
			if (req.valid && req.ready) begin
				case (req.action)
					ACT_FILTER: owed_samples.push_back(filter_sample(req.sample_in));
					ACT_LOAD: begin
						if (req.coef_index < TAPS)
							coef_tab[req.coef_index] = req.coef_value;
					end
					ACT_CLEAR: begin
						foreach (history[k])
							history[k] = '0;
					end
					default: ;
				endcase
			end
			results_owed <= owed_samples.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/fir_filter_direct_form_core_tb.sv =====
// Testbench top for the direct-form FIR filter core: clock, reset, stimulus and
// verdict. Depends on fir_pkg, fir_ifs.sv, the core and the checker module.
`default_nettype none

module fir_filter_direct_form_core_tb import fir_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAPS   = 64;
	localparam int SETTLE = TAPS + 16;
	localparam int LIMIT  = 400000;

	localparam action_t ACT_UNUSED = 2'd3;
	localparam logic signed [COEF_W-1:0] COEF_MAX  = 18'sh1ffff;
	localparam logic signed [COEF_W-1:0] COEF_MIN  = 18'sh20000;
	localparam logic signed [COEF_W-1:0] COEF_HALF = 18'sd32768;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   fail_count;
	int   results_owed;
	int   cycle_count = 0;

	fir_req_if req ();
	fir_rsp_if rsp ();
	fir_cfg_if cfg ();

	fir_filter_direct_form_core #(.TAPS(TAPS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	fir_filter_direct_form_checker #(.TAPS(TAPS)) scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.cfg          (cfg),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		return calm ? 0 : int'($urandom_range(0, 7));
	endfunction

	// Valid is only lowered when a gap follows, so back-to-back words never see
	// a low and a high scheduled in the same step.
	task automatic send_word(input action_t act, input logic signed [SAMPLE_W-1:0] smp,
			input logic [INDEX_W-1:0] idx, input logic signed [COEF_W-1:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.action     <= act;
		req.sample_in  <= smp;
		req.coef_index <= idx;
		req.coef_value <= val;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic hold_until_empty();
		req.valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	// A clear or a load leaves no result behind, so the core is given time to
	// finish a history sweep before the tap count changes.
	task automatic set_taps(input logic [TAPCNT_W-1:0] n);
		hold_until_empty();
		repeat (SETTLE) @(posedge clk);
		cfg.valid     <= 1'b1;
		cfg.tap_count <= n;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_word(input int taps_live);
		int                          r;
		action_t                     act;
		logic signed [SAMPLE_W-1:0]  smp;
		logic [INDEX_W-1:0]          idx;
		logic signed [COEF_W-1:0]    val;
		r = $urandom_range(0, 99);
		if (r < 72)
			act = ACT_FILTER;
		else if (r < 90)
			act = ACT_LOAD;
		else if (r < 95)
			act = ACT_CLEAR;
		else
			act = ACT_UNUSED;
		r = $urandom_range(0, 9);
		if (r == 0)
			smp = OUT_MAX;
		else if (r == 1)
			smp = OUT_MIN;
		else
			smp = SAMPLE_W'($urandom);
		if ($urandom_range(0, 9) < 7)
			idx = INDEX_W'($urandom_range(0, taps_live - 1));
		else
			idx = INDEX_W'($urandom);
		r = $urandom_range(0, 9);
		if (r == 0)
			val = COEF_MAX;
		else if (r == 1)
			val = COEF_MIN;
		else if (r < 5)
			val = COEF_W'($urandom);
		else
			val = COEF_W'(int'($urandom_range(0, 32767)) - 16384);
		send_word(act, smp, idx, val);
	endtask

	initial begin
		rsp.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			int stall;
			stall = pick_gap();
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	initial begin
		int taps_plan [6];
		int live;
		arst_n         <= 1'b0;
		calm            = 1'b0;
		req.valid      <= 1'b0;
		req.action     <= ACT_FILTER;
		req.sample_in  <= '0;
		req.coef_index <= '0;
		req.coef_value <= '0;
		cfg.valid      <= 1'b0;
		cfg.tap_count  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Single tap: extremes of the sample and of coefficient 0, rounding ties
		// and a word with an undefined action.
		set_taps('0);
		send_word(ACT_FILTER, OUT_MAX, '0, '0);
		send_word(ACT_FILTER, OUT_MIN, '0, '0);
		send_word(ACT_LOAD, '0, '0, COEF_MIN);
		send_word(ACT_FILTER, OUT_MIN, '0, '0);
		send_word(ACT_FILTER, OUT_MAX, '0, '0);
		send_word(ACT_LOAD, '0, '0, COEF_MAX);
		send_word(ACT_FILTER, OUT_MAX, '0, '0);
		send_word(ACT_LOAD, '0, '0, COEF_HALF);
		send_word(ACT_FILTER, 16'sd1, '0, '0);
		send_word(ACT_FILTER, -16'sd1, '0, '0);
		send_word(ACT_FILTER, 16'sd3, '0, '0);
		send_word(ACT_FILTER, -16'sd3, '0, '0);
		send_word(ACT_UNUSED, OUT_MIN, '1, COEF_MAX);
		send_word(ACT_LOAD, '0, '0, COEF_UNITY);

		// A tap count above the table size, the last tap and a history clear.
		set_taps(7'd127);
		send_word(ACT_LOAD, '0, 6'd63, COEF_MAX);
		send_word(ACT_LOAD, '0, 6'd1, -COEF_UNITY);
		send_word(ACT_FILTER, OUT_MAX, '0, '0);
		send_word(ACT_FILTER, OUT_MIN, '0, '0);
		send_word(ACT_CLEAR, OUT_MAX, '1, COEF_MIN);
		send_word(ACT_FILTER, 16'sd100, '0, '0);
		send_word(ACT_FILTER, OUT_MIN, '0, '0);

		taps_plan = '{64, 1, 0, 127, 2, 17};
		taps_plan[4] = $urandom_range(2, 63);
		for (int p = 0; p < 6; p++) begin
			set_taps(TAPCNT_W'(taps_plan[p]));
			live = taps_plan[p];
			if (live < 1)
				live = 1;
			if (live > TAPS)
				live = TAPS;
			calm = (p == 2);
			for (int k = 0; k < 75; k++) begin
				if (p != 2 && $urandom_range(0, 24) == 0)
					calm = !calm;
				if (p == 3 && k == 37)
					hold_until_empty();
				random_word(live);
			end
		end
		calm = 1'b0;

		hold_until_empty();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && results_owed == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
